/* hw/rtl/whpc_pkg.sv */
// ----------------------------------------------------------------------------
// Waypoint heading controller package
// Shared widths, register and state codes, and the arctangent angle table.
// ----------------------------------------------------------------------------
package whpc_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;
  localparam int ATAN_STEPS_DEF    = 16;

  localparam int IN_W       = 112;
  localparam int OUT_W      = 80;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int DIFF_W  = 25;  // waypoint minus position, Q16.8
  localparam int XY_W    = 48;  // rotation vector
  localparam int Z_W     = 28;  // accumulated angle, Q.24
  localparam int MUL_W   = 26;  // shared multiplier operand
  localparam int PROD_W  = 52;
  localparam int LEVEL_W = 22;
  localparam int ERR_W   = 17;
  localparam int EFF_W   = 21;

  localparam logic signed [15:0]    PI_Q13      = 16'sd25736;
  localparam logic signed [17:0]    TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN   = 3'd0,
    CFG_BASE   = 3'd1,
    CFG_LSCALE = 3'd2,
    CFG_RSCALE = 3'd3,
    CFG_RADIUS = 3'd4,
    CFG_MINSAT = 3'd5,
    CFG_TOTAL  = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_SQR,
    ST_CMP,
    ST_CSTART,
    ST_CWAIT,
    ST_ERR,
    ST_EMUL,
    ST_ECLAMP,
    ST_LMUL,
    ST_LCLAMP,
    ST_RCLAMP,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ITER,
    CS_ROUND
  } cordic_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  // Rotation angles atan(2^-i) in Q.24 radians.
  function automatic logic signed [Z_W-1:0] atan_angle(input logic [4:0] step);
    logic signed [Z_W-1:0] a;
    case (step)
      5'd0:  a = 28'sd13176795;
      5'd1:  a = 28'sd7778716;
      5'd2:  a = 28'sd4110060;
      5'd3:  a = 28'sd2086331;
      5'd4:  a = 28'sd1047214;
      5'd5:  a = 28'sd524117;
      5'd6:  a = 28'sd262123;
      5'd7:  a = 28'sd131069;
      5'd8:  a = 28'sd65536;
      5'd9:  a = 28'sd32768;
      5'd10: a = 28'sd16384;
      5'd11: a = 28'sd8192;
      5'd12: a = 28'sd4096;
      5'd13: a = 28'sd2048;
      5'd14: a = 28'sd1024;
      5'd15: a = 28'sd512;
      5'd16: a = 28'sd256;
      5'd17: a = 28'sd128;
      5'd18: a = 28'sd64;
      5'd19: a = 28'sd32;
      5'd20: a = 28'sd16;
      5'd21: a = 28'sd8;
      5'd22: a = 28'sd4;
      5'd23: a = 28'sd2;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/waypoint_heading_p_controller.sv */
// ----------------------------------------------------------------------------
// Waypoint heading controller
// Follows a table of waypoints and steers two drives with a proportional
// heading loop, using one shared multiplier and an iterative arctangent.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake            Payload
//  s_*       in         s_tvalid / s_tready  tuser = func, tdata = load or position
//  m_*       out        m_tvalid / m_tready  tdata = effort, drives, angles, status
//  cfg_*     in         cfg_we               cfg_index selects, cfg_data value
//
// A load item or a position item with too few satellites goes from the accept
// cycle straight to the output state. A position item that steers reads its
// waypoint, checks the radius and runs the arctangent unit, one rotation per
// cycle, before it forms effort and drives; on arrival it first reads the next
// waypoint, and a zero vector skips the rotations. A position item past the
// last waypoint, or the item that reaches it, clears both drives instead.
// Reset (rst, synchronous) clears the sequencer, the held outputs and the
// target index and loads the register defaults; the waypoint table keeps
// whatever it held. The block takes one item at a time: s_tready is high
// only in the idle state, and a result held back by m_tready stalls it.
module waypoint_heading_p_controller #(
  parameter int MAX_WAYPOINTS = whpc_pkg::MAX_WAYPOINTS_DEF,
  parameter int ATAN_STEPS    = whpc_pkg::ATAN_STEPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // entry_index, entry_x, entry_y, pos_x, pos_y, heading_in, satellite_count
  input  logic [whpc_pkg::IN_W-1:0]           s_tdata,
  // func
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // effort, left_drive, right_drive, heading_out, bearing_out, waypoint_now,
  // fix_ok, path_done
  output logic [whpc_pkg::OUT_W-1:0]          m_tdata,
  input  logic                                cfg_we,
  input  logic [whpc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [whpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

  // Configuration registers.
  logic [15:0] gain;
  logic [7:0]  base;
  logic [11:0] lscale, rscale;
  logic [15:0] radius;
  logic [4:0]  minsat;
  logic [6:0]  total;

  // Input fields.
  logic [5:0]         in_idx;
  logic signed [15:0] in_ex, in_ey, in_hd;
  logic signed [23:0] in_px, in_py;
  logic [4:0]         in_sat;

  assign in_idx = s_tdata[5:0];
  assign in_ex  = s_tdata[21:6];
  assign in_ey  = s_tdata[37:22];
  assign in_px  = s_tdata[61:38];
  assign in_py  = s_tdata[85:62];
  assign in_hd  = s_tdata[101:86];
  assign in_sat = s_tdata[106:102];

  whpc_pkg::state_t state, state_next;

  logic [6:0]                           target;
  logic                                 fix;
  logic                                 checked;
  logic signed [whpc_pkg::EFF_W-1:0]    held_effort;
  logic [7:0]                           held_left, held_right;
  logic signed [15:0]                   held_heading, held_bearing;

  logic signed [23:0]                   pos_x, pos_y;
  logic signed [15:0]                   heading_r;
  logic signed [whpc_pkg::DIFF_W-1:0]   dx, dy;
  logic [49:0]                          d2;
  logic signed [whpc_pkg::ERR_W-1:0]    err;

  // Waypoint table: x in the low half of a word, y in the high half.
  logic [31:0] tab [MAX_WAYPOINTS];
  logic [31:0] rd_data;
  logic        wr_en;

  logic [6:0] tot_eff;
  logic       path_done;
  logic       last_hit;
  logic       accept;

  assign tot_eff   = (int'(total) < MAX_WAYPOINTS) ? total : 7'(MAX_WAYPOINTS);
  assign path_done = (target >= tot_eff);
  assign last_hit  = ((target + 7'd1) >= tot_eff);
  assign accept    = s_tvalid && s_tready;
  assign wr_en     = accept && !s_tuser && (int'(in_idx) < MAX_WAYPOINTS);

  assign s_tready = (state == whpc_pkg::ST_IDLE);
  assign m_tvalid = (state == whpc_pkg::ST_OUT);
  assign m_tdata  = {2'b00, path_done, fix, target, held_bearing, held_heading,
                     held_right, held_left, held_effort};

  // Shared multiplier; its product register feeds the next step.
  logic signed [whpc_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [whpc_pkg::PROD_W-1:0]  prod;
  logic signed [whpc_pkg::LEVEL_W-1:0] lvl_l, lvl_r;

  assign lvl_l = $signed({6'b0, base, 8'b0}) - whpc_pkg::LEVEL_W'(held_effort);
  assign lvl_r = $signed({6'b0, base, 8'b0}) + whpc_pkg::LEVEL_W'(held_effort);

  always_comb begin
    case (state)
      whpc_pkg::ST_SQX: begin
        mul_a = whpc_pkg::MUL_W'(dx);
        mul_b = whpc_pkg::MUL_W'(dx);
      end
      whpc_pkg::ST_SQY: begin
        mul_a = whpc_pkg::MUL_W'(dy);
        mul_b = whpc_pkg::MUL_W'(dy);
      end
      whpc_pkg::ST_SQR: begin
        mul_a = $signed({10'b0, radius});
        mul_b = $signed({10'b0, radius});
      end
      whpc_pkg::ST_EMUL: begin
        mul_a = $signed({10'b0, gain});
        mul_b = whpc_pkg::MUL_W'(err);
      end
      whpc_pkg::ST_LMUL: begin
        mul_a = whpc_pkg::MUL_W'(lvl_l);
        mul_b = $signed({14'b0, lscale});
      end
      whpc_pkg::ST_LCLAMP: begin
        mul_a = whpc_pkg::MUL_W'(lvl_r);
        mul_b = $signed({14'b0, rscale});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Drive level from a Q.16 product: zero when not positive, rounded, capped.
  function automatic logic [7:0] drive_of(input logic signed [whpc_pkg::PROD_W-1:0] v);
    logic signed [whpc_pkg::PROD_W-1:0] t;
    logic [7:0] d;
    t = (v + 52'sd32768) >>> 16;
    if (v <= 0) begin
      d = 8'd0;
    end else if (t > 52'sd255) begin
      d = 8'd255;
    end else begin
      d = 8'(t);
    end
    return d;
  endfunction

  // Effort from gain times error, rounded and held to 21 bits.
  logic signed [whpc_pkg::PROD_W-1:0] eff_t;
  logic signed [whpc_pkg::EFF_W-1:0]  eff_c;

  assign eff_t = (prod + 52'sd4096) >>> 13;

  always_comb begin
    if (eff_t > 52'sd1048575) begin
      eff_c = 21'sd1048575;
    end else if (eff_t < -52'sd1048576) begin
      eff_c = -21'sd1048576;
    end else begin
      eff_c = whpc_pkg::EFF_W'(eff_t);
    end
  end

  // Heading error wrapped into one turn about zero.
  logic signed [17:0] err_raw, err_w;

  assign err_raw = 18'(held_bearing) - 18'(held_heading);

  always_comb begin
    if (err_raw < -18'(whpc_pkg::PI_Q13)) begin
      err_w = err_raw + whpc_pkg::TWO_PI_Q13;
    end else if (err_raw > 18'(whpc_pkg::PI_Q13)) begin
      err_w = err_raw - whpc_pkg::TWO_PI_Q13;
    end else begin
      err_w = err_raw;
    end
  end

  // Arctangent unit.
  whpc_pkg::cordic_stat_t cordic_stat;
  logic signed [15:0]     cordic_bearing;

  whpc_cordic #(
    .ATAN_STEPS (ATAN_STEPS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == whpc_pkg::ST_CSTART),
    .dx      (dx),
    .dy      (dy),
    .stat    (cordic_stat),
    .bearing (cordic_bearing)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      whpc_pkg::ST_IDLE: begin
        if (accept) begin
          if (!s_tuser || in_sat < minsat) begin
            state_next = whpc_pkg::ST_OUT;
          end else if (!path_done) begin
            state_next = whpc_pkg::ST_READ;
          end else begin
            state_next = whpc_pkg::ST_FIN;
          end
        end
      end
      whpc_pkg::ST_READ:   state_next = whpc_pkg::ST_DIFF;
      whpc_pkg::ST_DIFF:   state_next = checked ? whpc_pkg::ST_CSTART : whpc_pkg::ST_SQX;
      whpc_pkg::ST_SQX:    state_next = whpc_pkg::ST_SQY;
      whpc_pkg::ST_SQY:    state_next = whpc_pkg::ST_SQR;
      whpc_pkg::ST_SQR:    state_next = whpc_pkg::ST_CMP;
      whpc_pkg::ST_CMP: begin
        if (d2 < {18'b0, prod[31:0]}) begin
          state_next = last_hit ? whpc_pkg::ST_FIN : whpc_pkg::ST_READ;
        end else begin
          state_next = whpc_pkg::ST_CSTART;
        end
      end
      whpc_pkg::ST_CSTART: state_next = whpc_pkg::ST_CWAIT;
      whpc_pkg::ST_CWAIT: begin
        if (cordic_stat.done) begin
          state_next = whpc_pkg::ST_ERR;
        end
      end
      whpc_pkg::ST_ERR:    state_next = whpc_pkg::ST_EMUL;
      whpc_pkg::ST_EMUL:   state_next = whpc_pkg::ST_ECLAMP;
      whpc_pkg::ST_ECLAMP: state_next = whpc_pkg::ST_LMUL;
      whpc_pkg::ST_LMUL:   state_next = whpc_pkg::ST_LCLAMP;
      whpc_pkg::ST_LCLAMP: state_next = whpc_pkg::ST_RCLAMP;
      whpc_pkg::ST_RCLAMP: state_next = whpc_pkg::ST_OUT;
      whpc_pkg::ST_FIN:    state_next = whpc_pkg::ST_OUT;
      whpc_pkg::ST_OUT: begin
        if (m_tready) begin
          state_next = whpc_pkg::ST_IDLE;
        end
      end
      default: state_next = whpc_pkg::ST_IDLE;
    endcase
  end

  // Control and held outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= whpc_pkg::ST_IDLE;
      target       <= '0;
      fix          <= 1'b0;
      checked      <= 1'b0;
      held_effort  <= '0;
      held_left    <= '0;
      held_right   <= '0;
      held_heading <= '0;
      held_bearing <= '0;
      gain         <= 16'd256;
      base         <= 8'd128;
      lscale       <= 12'd256;
      rscale       <= 12'd256;
      radius       <= 16'd768;
      minsat       <= 5'd4;
      total        <= 7'd0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (whpc_pkg::cfg_reg_t'(cfg_index))
          whpc_pkg::CFG_GAIN:   gain   <= cfg_data;
          whpc_pkg::CFG_BASE:   base   <= cfg_data[7:0];
          whpc_pkg::CFG_LSCALE: lscale <= cfg_data[11:0];
          whpc_pkg::CFG_RSCALE: rscale <= cfg_data[11:0];
          whpc_pkg::CFG_RADIUS: radius <= cfg_data;
          whpc_pkg::CFG_MINSAT: minsat <= cfg_data[4:0];
          whpc_pkg::CFG_TOTAL:  total  <= cfg_data[6:0];
          default: ;
        endcase
      end
      case (state)
        whpc_pkg::ST_IDLE: begin
          checked <= 1'b0;
          if (accept && s_tuser) begin
            fix <= (in_sat >= minsat);
          end
        end
        whpc_pkg::ST_CMP: begin
          if (d2 < {18'b0, prod[31:0]}) begin
            target  <= target + 7'd1;
            checked <= 1'b1;
          end
        end
        whpc_pkg::ST_CWAIT: begin
          if (cordic_stat.done) begin
            held_bearing <= cordic_bearing;
            held_heading <= heading_r;
          end
        end
        whpc_pkg::ST_ECLAMP: held_effort <= eff_c;
        whpc_pkg::ST_LCLAMP: held_left   <= drive_of(prod);
        whpc_pkg::ST_RCLAMP: held_right  <= drive_of(prod);
        whpc_pkg::ST_FIN: begin
          held_left  <= '0;
          held_right <= '0;
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (accept) begin
      pos_x     <= in_px;
      pos_y     <= in_py;
      heading_r <= in_hd;
    end
    case (state)
      whpc_pkg::ST_DIFF: begin
        dx <= $signed({rd_data[15], rd_data[15:0], 8'b0}) - whpc_pkg::DIFF_W'(pos_x);
        dy <= $signed({rd_data[31], rd_data[31:16], 8'b0}) - whpc_pkg::DIFF_W'(pos_y);
      end
      whpc_pkg::ST_SQY: d2  <= prod[49:0];
      whpc_pkg::ST_SQR: d2  <= d2 + prod[49:0];
      whpc_pkg::ST_ERR: err <= whpc_pkg::ERR_W'(err_w);
      default: ;
    endcase
  end

  // Table write on a load item, registered read at the target index.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab[AW'(in_idx)] <= {in_ey, in_ex};
    end
    rd_data <= tab[AW'(target)];
  end

  // A result is never offered while a new item can be taken.
  assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is pending");

  // The arctangent unit only runs while the sequencer waits on it.
  assert property (@(posedge clk) disable iff (rst)
      (cordic_stat.busy || cordic_stat.done) |-> state == whpc_pkg::ST_CWAIT)
    else $error("arctangent unit active outside its wait state");

  // Arrival inside the radius moves the target by exactly one.
  assert property (@(posedge clk) disable iff (rst)
      (state == whpc_pkg::ST_CMP && d2 < {18'b0, prod[31:0]})
      |=> target == $past(target) + 7'd1)
    else $error("target index did not advance on arrival");

  // Past the last waypoint both drives are off after the finish state.
  assert property (@(posedge clk) disable iff (rst)
      (state == whpc_pkg::ST_FIN) |=> (held_left == 8'd0 && held_right == 8'd0))
    else $error("drives not cleared at end of path");

endmodule

/* hw/rtl/whpc_cordic.sv */
// ----------------------------------------------------------------------------
// Iterative arctangent unit
// Vectoring-mode rotation, one step per cycle, result rounded to Q3.13.
// ----------------------------------------------------------------------------
module whpc_cordic #(
  parameter int ATAN_STEPS = whpc_pkg::ATAN_STEPS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  input  logic signed [whpc_pkg::DIFF_W-1:0]     dx,
  input  logic signed [whpc_pkg::DIFF_W-1:0]     dy,
  output whpc_pkg::cordic_stat_t                 stat,
  output logic signed [15:0]                     bearing
);

  localparam int CW = (ATAN_STEPS > 1) ? $clog2(ATAN_STEPS) : 1;

  whpc_pkg::cordic_state_t cstate, cstate_next;
  logic signed [whpc_pkg::XY_W-1:0] x, y, xs, ys, x0, y0;
  logic signed [whpc_pkg::Z_W-1:0]  z;
  logic [CW-1:0]                    step;
  logic                             done;
  logic signed [whpc_pkg::Z_W-1:0]  zr;
  logic signed [whpc_pkg::Z_W-12:0] r;

  assign x0 = whpc_pkg::XY_W'(dx) <<< 20;
  assign y0 = whpc_pkg::XY_W'(dy) <<< 20;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign zr = z + 28'sd1024;
  assign r  = zr[whpc_pkg::Z_W-1:11];

  assign stat.busy = (cstate != whpc_pkg::CS_IDLE);
  assign stat.done = done;

  always_comb begin
    cstate_next = cstate;
    case (cstate)
      whpc_pkg::CS_IDLE: begin
        if (start) begin
          cstate_next = (dx == '0 && dy == '0) ? whpc_pkg::CS_ROUND : whpc_pkg::CS_ITER;
        end
      end
      whpc_pkg::CS_ITER: begin
        if (step == CW'(ATAN_STEPS - 1)) begin
          cstate_next = whpc_pkg::CS_ROUND;
        end
      end
      whpc_pkg::CS_ROUND: cstate_next = whpc_pkg::CS_IDLE;
      default: cstate_next = whpc_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cstate <= whpc_pkg::CS_IDLE;
      done   <= 1'b0;
    end else begin
      cstate <= cstate_next;
      done   <= (cstate == whpc_pkg::CS_ROUND);
    end
  end

  always_ff @(posedge clk) begin
    case (cstate)
      whpc_pkg::CS_IDLE: begin
        step <= '0;
        if (start) begin
          if (dx == '0 && dy == '0) begin
            z <= '0;
          end else if (x0 < 0) begin
            // Left half plane: turn by a quarter first.
            if (y0 >= 0) begin
              x <= y0;
              y <= -x0;
              z <= whpc_pkg::HALF_PI_Q24;
            end else begin
              x <= -y0;
              y <= x0;
              z <= -whpc_pkg::HALF_PI_Q24;
            end
          end else begin
            x <= x0;
            y <= y0;
            z <= '0;
          end
        end
      end
      whpc_pkg::CS_ITER: begin
        step <= step + 1'b1;
        if (y >= 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + whpc_pkg::atan_angle(5'(step));
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - whpc_pkg::atan_angle(5'(step));
        end
      end
      whpc_pkg::CS_ROUND: begin
        if (r > 17'(whpc_pkg::PI_Q13)) begin
          bearing <= whpc_pkg::PI_Q13;
        end else if (r < -17'(whpc_pkg::PI_Q13)) begin
          bearing <= -whpc_pkg::PI_Q13;
        end else begin
          bearing <= 16'(r);
        end
      end
      default: ;
    endcase
  end

endmodule
